@@ design/encoder_and_button_qualifier_defines.svh @@
// ----------------------------------------------------------------------------
// encoder_and_button_qualifier_defines
// Assertion macros shared by the encoder and button qualifier.
// ----------------------------------------------------------------------------
`ifndef ENCODER_AND_BUTTON_QUALIFIER_DEFINES_SVH
`define ENCODER_AND_BUTTON_QUALIFIER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define EBQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define EBQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ebq_pkg.sv @@
// ----------------------------------------------------------------------------
// ebq_pkg
// Widths, channel indexes and shared types of the encoder and button qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebq_pkg;

  localparam int unsigned PosW        = 32;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned DebounceW   = 16;
  localparam int unsigned AngleW      = 9;
  localparam int unsigned FullTurn    = 360;
  localparam int unsigned AngleStepDefault = 10;
  localparam logic [DebounceW-1:0] DebounceReset = 16'd50;

  // Debounced channels
  localparam int unsigned NumChan   = 3;
  localparam int unsigned ChSwitch  = 0;
  localparam int unsigned ChButtonA = 1;
  localparam int unsigned ChButtonB = 2;

  // Encoder state after the current sample
  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [PosW-1:0]   position;
  } enc_state_t;

  // Debouncer status after the current sample
  typedef struct packed {
    logic stable;
    logic rose;
  } deb_status_t;

endpackage

`default_nettype wire

@@ design/ebq_sample_if.sv @@
// ----------------------------------------------------------------------------
// ebq_sample_if
// Request channel carrying one pin sample and its millisecond timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ebq_sample_if;
  logic        valid;
  logic        ready;
  logic        enc_a_level;
  logic        enc_b_level;
  logic        switch_level;
  logic        button_a_level;
  logic        button_b_level;
  logic [31:0] now_ms;

  modport source (
    output valid, enc_a_level, enc_b_level, switch_level, button_a_level,
           button_b_level, now_ms,
    input  ready
  );

  modport sink (
    input  valid, enc_a_level, enc_b_level, switch_level, button_a_level,
           button_b_level, now_ms,
    output ready
  );
endinterface

`default_nettype wire

@@ design/ebq_result_if.sv @@
// ----------------------------------------------------------------------------
// ebq_result_if
// Request channel carrying the qualified encoder and button state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ebq_result_if;
  logic               valid;
  logic               ready;
  logic [8:0]         angle_deg;
  logic signed [31:0] position;
  logic               switch_pressed_pulse;
  logic               button_a_stable;
  logic               button_b_stable;

  modport source (
    output valid, angle_deg, position, switch_pressed_pulse, button_a_stable,
           button_b_stable,
    input  ready
  );

  modport sink (
    input  valid, angle_deg, position, switch_pressed_pulse, button_a_stable,
           button_b_stable,
    output ready
  );
endinterface

`default_nettype wire

@@ design/encoder_and_button_qualifier.sv @@
// ----------------------------------------------------------------------------
// encoder_and_button_qualifier
// Quadrature encoder count and angle with debounced switch and buttons.
//
//   channel    dir  handshake      carries
//   sample_i   in   valid/ready    encoder A/B, switch, buttons, now_ms
//   result_o   out  valid/ready    angle, position, press pulse, buttons
//   cfg        in   cfg_we_i       settle time in ms
//
// One request per cycle while result_o accepts; a taken request passes the
// input register, then the result register.
// The state update sits between the two registers and commits as a request
// moves into the result register, so a stalled result freezes both stages.
// Reset: encoder A taken as high, count, angle and buttons released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_and_button_qualifier_defines.svh"

module encoder_and_button_qualifier #(
  parameter int unsigned AngleStep = ebq_pkg::AngleStepDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ebq_sample_if.sink                         sample_i,
  ebq_result_if.source                       result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ebq_pkg::DebounceW-1:0] cfg_wdata_i
);
  import ebq_pkg::*;

  logic [DebounceW-1:0] settle_ms_q;

  logic               in_valid_q;
  logic               a_q, b_q;
  logic [NumChan-1:0] level_q;
  logic [TimeW-1:0]   now_q;
  logic               advance;

  enc_state_t         enc_state;
  deb_status_t        deb_status [NumChan];
  logic [NumChan-1:0] pressed;

  logic               out_valid_q;
  logic [AngleW-1:0]  angle_q;
  logic [PosW-1:0]    position_q;
  logic               pulse_q, btn_a_q, btn_b_q;

  // Hold the debounce time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ms_q <= DebounceReset;
    end else if (cfg_we_i) begin
      settle_ms_q <= cfg_wdata_i;
    end
  end

  // Advance the input stage whenever the result register is free
  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || advance;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      a_q     <= sample_i.enc_a_level;
      b_q     <= sample_i.enc_b_level;
      level_q <= {sample_i.button_b_level, sample_i.button_a_level,
                  sample_i.switch_level};
      now_q   <= sample_i.now_ms;
    end
  end

  ebq_encoder #(
    .AngleStep (AngleStep)
  ) u_encoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .a_i     (a_q),
    .b_i     (b_q),
    .state_o (enc_state)
  );

  // Pins are active low: pressed means a low level
  assign pressed = ~level_q;

  for (genvar i = 0; i < NumChan; i++) begin : g_deb
    ebq_debounce u_debounce (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (advance),
      .pressed_i   (pressed[i]),
      .now_i       (now_q),
      .settle_ms_i (settle_ms_q),
      .status_o    (deb_status[i])
    );
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      angle_q    <= enc_state.angle;
      position_q <= enc_state.position;
      pulse_q    <= deb_status[ChSwitch].rose;
      btn_a_q    <= deb_status[ChButtonA].stable;
      btn_b_q    <= deb_status[ChButtonB].stable;
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.angle_deg            = angle_q;
  assign result_o.position             = $signed(position_q);
  assign result_o.switch_pressed_pulse = pulse_q;
  assign result_o.button_a_stable      = btn_a_q;
  assign result_o.button_b_stable      = btn_b_q;

  // Checks
  `EBQ_ASSERT_SAME(a_angle_range, clk_i, rst_ni, out_valid_q,
                   angle_q < AngleW'(FullTurn), "angle out of range")
  `EBQ_ASSERT_NEXT(a_advance_fills, clk_i, rst_ni, advance, out_valid_q,
                   "advanced request lost")
  `EBQ_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_valid_q && !advance, in_valid_q,
                   "stalled request dropped")
  `EBQ_ASSERT_SAME(a_pulse_stable, clk_i, rst_ni, advance && deb_status[ChSwitch].rose,
                   deb_status[ChSwitch].stable, "pulse without pressed switch")

endmodule

`default_nettype wire

@@ design/ebq_encoder.sv @@
// ----------------------------------------------------------------------------
// ebq_encoder
// Quadrature count and incremental angle, updated once per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebq_encoder #(
  parameter int unsigned AngleStep = ebq_pkg::AngleStepDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                a_i,
  input  wire logic                b_i,
  output ebq_pkg::enc_state_t      state_o
);
  import ebq_pkg::*;

  localparam logic [AngleW-1:0] Step = AngleW'(AngleStep % FullTurn);
  localparam logic [AngleW-1:0] Back = AngleW'(FullTurn - (AngleStep % FullTurn));
  localparam logic [AngleW:0]   Turn = (AngleW+1)'(FullTurn);

  logic              a_prev_q;
  logic [PosW-1:0]   count_q, count_d;
  logic [AngleW-1:0] angle_q, angle_d;
  logic [AngleW:0]   up_sum;

  // Step the count and angle when channel A changes
  always_comb begin
    up_sum  = {1'b0, angle_q} + {1'b0, Step};
    count_d = count_q;
    angle_d = angle_q;
    if (a_i != a_prev_q) begin
      if (a_i == b_i) begin
        count_d = count_q + PosW'(1);
        angle_d = (up_sum >= Turn) ? AngleW'(up_sum - Turn) : up_sum[AngleW-1:0];
      end else begin
        count_d = count_q - PosW'(1);
        angle_d = (angle_q >= Step) ? angle_q - Step : angle_q + Back;
      end
    end
  end

  // Commit on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_prev_q <= 1'b1;
      count_q  <= '0;
      angle_q  <= '0;
    end else if (en_i) begin
      a_prev_q <= a_i;
      count_q  <= count_d;
      angle_q  <= angle_d;
    end
  end

  assign state_o.angle    = angle_d;
  assign state_o.position = count_d;

endmodule

`default_nettype wire

@@ design/ebq_debounce.sv @@
// ----------------------------------------------------------------------------
// ebq_debounce
// Timestamp debouncer for one active-high pressed level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebq_debounce (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            pressed_i,
  input  wire logic [ebq_pkg::TimeW-1:0]       now_i,
  input  wire logic [ebq_pkg::DebounceW-1:0]   settle_ms_i,
  output ebq_pkg::deb_status_t                 status_o
);
  import ebq_pkg::*;

  logic             raw_q, raw_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_q, change_d;
  logic [TimeW-1:0] elapsed;

  // Restart the timer on a raw change, else settle once held long enough
  always_comb begin
    elapsed  = now_i - change_q;
    raw_d    = raw_q;
    change_d = change_q;
    stable_d = stable_q;
    if (pressed_i != raw_q) begin
      raw_d    = pressed_i;
      change_d = now_i;
    end else if (elapsed > TimeW'(settle_ms_i)) begin
      stable_d = raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      change_q <= '0;
    end else if (en_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      change_q <= change_d;
    end
  end

  assign status_o.stable = stable_d;
  assign status_o.rose   = stable_d & ~stable_q;

endmodule

`default_nettype wire
